>>> sv/ggc_pkg.sv
// Shared constants and types for the greedy graph coloring core.
`timescale 1ns / 1ps
package ggc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int ROW_BITS     = 32;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int COLOR_W      = 6;
	localparam int CNT_W        = 6;
	localparam int USED_W       = 1 << COLOR_W;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		color_t             wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} ram_req_t;

	typedef struct packed {
		color_t vertex_color;
		color_t colors_used;
		logic   last_vertex;
	} ggc_res_t;

endpackage

>>> sv/ggc_if.sv
// Valid/ready channel interfaces for input, result and configuration beats.
`timescale 1ns / 1ps
interface ggc_in_if import ggc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ROW_BITS-1:0] conflict_row;
	logic                start_graph;

	modport source (output valid, output conflict_row, output start_graph, input ready);
	modport sink (input valid, input conflict_row, input start_graph, output ready);
endinterface

interface ggc_out_if import ggc_pkg::*;;
	logic   valid;
	logic   ready;
	color_t vertex_color;
	color_t colors_used;
	logic   last_vertex;

	modport source (output valid, output vertex_color, output colors_used, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_color, input colors_used, input last_vertex,
		output ready);
endinterface

interface ggc_cfg_if import ggc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

>>> sv/ggc_color_ram.sv
// Color store: one write port, one registered read port.
`timescale 1ns / 1ps
module ggc_color_ram import ggc_pkg::*; (
	input  logic     clk,
	input  ram_req_t req,
	output color_t   rdata
);

	color_t mem [MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> sv/ggc_seq.sv
// Per-vertex sequencer: gathers neighbor colors, picks first fit, writes back.
`timescale 1ns / 1ps
module ggc_seq import ggc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROW_BITS-1:0] conflict_row,
	input  logic                start_graph,
	input  logic [CNT_W-1:0]    vertex_count,
	output ram_req_t            ram_req,
	input  color_t              ram_rdata,
	output logic                res_valid,
	input  logic                res_take,
	output ggc_res_t            res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]          state_q;
	logic [ROW_BITS-1:0] row_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    j_q;
	logic [CNT_W-1:0]    vidx_q;
	color_t              max_q;
	logic [USED_W-1:0]   used_q;
	logic                hit_s1;

	logic                accept;
	logic [CNT_W-1:0]    vidx_cur;
	logic [IDX_W-1:0]    idx_new;
	color_t              color;
	color_t              max_base;
	color_t              max_new;
	logic [CNT_W-1:0]    n_eff;
	logic [CNT_W-1:0]    idx_inc;
	logic                last;
	logic                rd_en;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign vidx_cur = start_graph ? '0 : vidx_q;
	assign idx_new  = (vidx_cur >= CNT_W'(MAX_VERTICES)) ? IDX_W'(MAX_VERTICES - 1)
		: vidx_cur[IDX_W-1:0];
	assign rd_en    = (state_q == ST_READ);

	always_comb begin
		color = color_t'(USED_W - 1);
		for (int k = USED_W - 1; k >= 1; k--) begin
			if (!used_q[k]) begin
				color = color_t'(k);
			end
		end
	end

	always_comb begin
		if (vertex_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vertex_count;
		end
	end

	assign idx_inc  = CNT_W'(idx_q) + CNT_W'(1);
	assign last     = (idx_inc >= n_eff);
	assign max_base = (idx_q == '0) ? '0 : max_q;
	assign max_new  = (color > max_base) ? color : max_base;

	assign res_valid        = (state_q == ST_FIN);
	assign res.vertex_color = color;
	assign res.colors_used  = max_new;
	assign res.last_vertex  = last;

	assign ram_req.we    = res_take;
	assign ram_req.waddr = idx_q;
	assign ram_req.wdata = color;
	assign ram_req.re    = rd_en;
	assign ram_req.raddr = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vidx_q  <= '0;
			max_q   <= '0;
			hit_s1  <= 1'b0;
			j_q     <= '0;
			idx_q   <= '0;
		end else begin
			hit_s1 <= rd_en && row_q[j_q];
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= idx_new;
						j_q   <= '0;
						if (start_graph) begin
							max_q <= '0;
						end
						state_q <= (idx_new == '0) ? ST_FIN : ST_READ;
					end
				end
				ST_READ: begin
					if (j_q == idx_q - IDX_W'(1)) begin
						state_q <= ST_DRAIN;
					end
					j_q <= j_q + IDX_W'(1);
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_take) begin
						max_q   <= max_new;
						vidx_q  <= last ? '0 : idx_inc;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= conflict_row;
			used_q <= '0;
		end else if (hit_s1) begin
			used_q <= used_q | (USED_W'(1) << ram_rdata);
		end
	end

	a_read_below_idx: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |-> (ram_req.raddr < idx_q))
		else $error("read past current vertex");

	a_take_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> (state_q == ST_FIN))
		else $error("result taken outside finish");

	a_color_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> (res.vertex_color != '0 && res.vertex_color <= res.colors_used))
		else $error("color out of bounds");

	a_take_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted vertex not started");

endmodule

>>> sv/greedy_graph_coloring_core.sv
// Top level: config register, sequencer, color store and output register.
// Each vertex reads the colors of all earlier vertices through the single read port of the
// color store, one earlier vertex color read per cycle; vertex 0 reads none. A new vertex
// beat is taken only once the sequencer has handed its result to the output register.
// A new vertex beat is taken while the previous result still waits in the output register.
// Reset clears index, maximum and handshake state and sets vertex_count to 32, not the store.
`timescale 1ns / 1ps
module greedy_graph_coloring_core import ggc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	ggc_cfg_if.sink  cfg,
	ggc_in_if.sink   vertex_in,
	ggc_out_if.source color_out
);

	logic [CNT_W-1:0] vertex_count_q;
	logic             out_valid_q;
	ggc_res_t         out_q;
	ram_req_t         ram_req;
	color_t           ram_rdata;
	logic             res_valid;
	logic             res_take;
	ggc_res_t         res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CNT_W'(MAX_VERTICES);
		end else if (cfg.valid) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	ggc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (vertex_in.valid),
		.in_ready     (vertex_in.ready),
		.conflict_row (vertex_in.conflict_row),
		.start_graph  (vertex_in.start_graph),
		.vertex_count (vertex_count_q),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	ggc_color_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign res_take = res_valid && (!out_valid_q || color_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (color_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign color_out.valid        = out_valid_q;
	assign color_out.vertex_color = out_q.vertex_color;
	assign color_out.colors_used  = out_q.colors_used;
	assign color_out.last_vertex  = out_q.last_vertex;

endmodule

>>> tb/greedy_graph_coloring_core_tb.sv
// Testbench for greedy_graph_coloring_core: directed and random graphs, first-fit predictor.
`timescale 1ns / 1ps
module greedy_graph_coloring_core_tb;
	import ggc_pkg::*;

	localparam int ITEMS         = 400;
	localparam int MAX_IDLE      = 18;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ggc_cfg_if count_ch ();
	ggc_in_if  vertex_ch ();
	ggc_out_if color_ch ();

	greedy_graph_coloring_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (count_ch),
		.vertex_in(vertex_ch),
		.color_out(color_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	color_t           vertex_colors [MAX_VERTICES];
	int               next_vertex;
	color_t           top_color;
	logic [CNT_W-1:0] graph_size;

	ggc_res_t expected_colors [$];
	int       mismatches;
	int       items_sent;
	int       in_gap_max;
	int       out_stall_max;
	int       quiet_cycles = 0;

	function automatic int size_in_force(input logic [CNT_W-1:0] cnt);
		if (cnt == 0)
			return 1;
		if (cnt > MAX_VERTICES)
			return MAX_VERTICES;
		return int'(cnt);
	endfunction

	function automatic ggc_res_t color_vertex(input logic [ROW_BITS-1:0] row, input logic start);
		int            n;
		int            idx;
		logic [63:0]   used;
		color_t        c;
		bit            found;
		bit            last;
		ggc_res_t      r;
		n = size_in_force(graph_size);
		used = '0;
		found = 1'b0;
		if (start) begin
			next_vertex = 0;
			top_color = '0;
		end
		idx = next_vertex;
		if (idx >= MAX_VERTICES)
			idx = MAX_VERTICES - 1;
		if (idx == 0) begin
			top_color = '0;
			c = color_t'(1);
		end else begin
			for (int j = 0; j < ROW_BITS && j < idx; j++)
				if (row[j])
					used[vertex_colors[j]] = 1'b1;
			c = color_t'(63);
			for (int j = 1; j < 64; j++)
				if (!found && !used[j]) begin
					c = color_t'(j);
					found = 1'b1;
				end
		end
		vertex_colors[idx] = c;
		if (c > top_color)
			top_color = c;
		last = (idx + 1 >= n);
		next_vertex = last ? 0 : idx + 1;
		r.vertex_color = c;
		r.colors_used = top_color;
		r.last_vertex = last;
		return r;
	endfunction

	task automatic send_vertex(input logic [ROW_BITS-1:0] row, input logic start);
		int gap;
		gap = (in_gap_max != 0) ? $urandom_range(0, in_gap_max) : 0;
		if (gap != 0) begin
			vertex_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_ch.valid <= 1'b1;
		vertex_ch.conflict_row <= row;
		vertex_ch.start_graph <= start;
		do @(posedge clk); while (!vertex_ch.ready);
		expected_colors = {expected_colors, color_vertex(row, start)};
		items_sent++;
	endtask

	task automatic wait_idle();
		vertex_ch.valid <= 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] cnt);
		count_ch.valid <= 1'b1;
		count_ch.vertex_count <= cnt;
		do @(posedge clk); while (!count_ch.ready);
		count_ch.valid <= 1'b0;
		graph_size = cnt;
	endtask

	task automatic run_graph(input int len, input int mode, input bit use_start);
		logic [ROW_BITS-1:0] row;
		logic                start;
		for (int v = 0; v < len; v++) begin
			case (mode)
				0: row = $urandom;
				1: row = $urandom | $urandom;
				2: row = $urandom & $urandom & $urandom;
				default: row = '1;
			endcase
			start = (v == 0) ? use_start : ($urandom_range(0, 29) == 0);
			send_vertex(row, start);
		end
	endtask

	task automatic test_first_graph();
		send_vertex(32'hFFFF_FFFF, 1'b0);
		send_vertex(32'h0000_0001, 1'b0);
		send_vertex(32'h0000_0000, 1'b0);
		send_vertex(32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_restart_mid_graph();
		send_vertex(32'h8000_0000, 1'b1);
		send_vertex(32'hFFFF_FFFE, 1'b0);
		send_vertex(32'h0000_0003, 1'b0);
		send_vertex(32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_count_extremes();
		wait_idle();
		write_count('0);
		send_vertex(32'hFFFF_FFFF, 1'b0);
		send_vertex(32'hFFFF_FFFF, 1'b1);
		send_vertex(32'h0000_0000, 1'b0);
		wait_idle();
		write_count(CNT_W'(1));
		send_vertex(32'hFFFF_FFFF, 1'b0);
		send_vertex(32'hFFFF_FFFF, 1'b0);
		wait_idle();
		write_count('1);
		send_vertex(32'h5555_5555, 1'b1);
		send_vertex(32'hAAAA_AAAB, 1'b0);
		send_vertex(32'h0000_0003, 1'b0);
	endtask

	task automatic test_index_past_count();
		wait_idle();
		write_count(CNT_W'(2));
		send_vertex(32'h0000_0007, 1'b0);
		send_vertex(32'h0000_0001, 1'b0);
		send_vertex(32'h0000_0001, 1'b0);
		send_vertex(32'h0000_0000, 1'b0);
	endtask

	task automatic test_random_graphs();
		logic [CNT_W-1:0] cnt;
		int               n;
		int               len;
		int               graphs;
		wait_idle();
		write_count(CNT_W'(MAX_VERTICES));
		run_graph(MAX_VERTICES, 3, 1'b1);
		while (items_sent < ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 9))
				0: cnt = '0;
				1: cnt = '1;
				2: cnt = CNT_W'($urandom_range(MAX_VERTICES + 1, 62));
				3: cnt = CNT_W'(MAX_VERTICES);
				default: cnt = CNT_W'($urandom_range(1, 12));
			endcase
			write_count(cnt);
			in_gap_max = $urandom_range(0, 1) ? MAX_IDLE : 0;
			out_stall_max = $urandom_range(0, 1) ? MAX_IDLE : 0;
			n = size_in_force(cnt);
			graphs = $urandom_range(1, 4);
			for (int g = 0; g < graphs && items_sent < ITEMS; g++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
				run_graph(len, $urandom_range(0, 3), $urandom_range(0, 3) != 0);
			end
		end
	endtask

	initial begin
		vertex_ch.valid <= 1'b0;
		vertex_ch.conflict_row <= '0;
		vertex_ch.start_graph <= 1'b0;
		count_ch.valid <= 1'b0;
		count_ch.vertex_count <= '0;
		color_ch.ready <= 1'b0;
		for (int i = 0; i < MAX_VERTICES; i++)
			vertex_colors[i] = '0;
		next_vertex = 0;
		top_color = '0;
		graph_size = CNT_W'(MAX_VERTICES);
		mismatches = 0;
		items_sent = 0;
		in_gap_max = MAX_IDLE;
		out_stall_max = MAX_IDLE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_graph();
		test_restart_mid_graph();
		test_count_extremes();
		test_index_past_count();
		test_random_graphs();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_colors.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		ggc_res_t exp_res;
		int       stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (out_stall_max != 0) ? $urandom_range(0, out_stall_max) : 0;
			if (stall != 0) begin
				color_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			color_ch.ready <= 1'b1;
			do @(posedge clk); while (!color_ch.valid);
			if (expected_colors.size() == 0) begin
				$error("result beat with nothing expected: color %0d, used %0d, last %0b",
					color_ch.vertex_color, color_ch.colors_used, color_ch.last_vertex);
				mismatches++;
			end else begin
				exp_res = expected_colors.pop_front();
				if (color_ch.vertex_color !== exp_res.vertex_color) begin
					$error("vertex_color: expected %0d, actual %0d",
						exp_res.vertex_color, color_ch.vertex_color);
					mismatches++;
				end
				if (color_ch.colors_used !== exp_res.colors_used) begin
					$error("colors_used: expected %0d, actual %0d",
						exp_res.colors_used, color_ch.colors_used);
					mismatches++;
				end
				if (color_ch.last_vertex !== exp_res.last_vertex) begin
					$error("last_vertex: expected %0b, actual %0b",
						exp_res.last_vertex, color_ch.last_vertex);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((vertex_ch.valid && vertex_ch.ready) || (color_ch.valid && color_ch.ready) ||
				(count_ch.valid && count_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
